FILE: sv/srs_pkg.sv
// Shared types and constants for the stroke route sampler.
package srs_pkg;

    localparam logic [1:0] ACT_TOUCH   = 2'd0;
    localparam logic [1:0] ACT_MOVE    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_SPARE   = 2'd3;

    localparam logic [1:0] REG_BEND_LIMIT = 2'd0;
    localparam logic [1:0] REG_MIN_MOVE   = 2'd1;
    localparam logic [1:0] REG_GRID_RES   = 2'd2;

    localparam int ACCUM_BITS = 20;
    localparam logic [ACCUM_BITS-1:0] ACCUM_MAX = 20'hFFFFF;

    // Request and answer between the top level and the square-root unit.
    typedef struct packed {
        logic        go;
        logic [33:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] root;
    } sqrt_rsp_t;

endpackage

FILE: sv/srs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module srs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/srs_sqrt.sv
// Bit-serial floor integer square root, one result bit per cycle.
module srs_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  srs_pkg::sqrt_req_t req,
    output srs_pkg::sqrt_rsp_t rsp
);

    logic [33:0] rem_reg, rem_next;
    logic [16:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // Restoring digit recurrence: two radicand bits enter per step.
    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            rem_next  = req.radicand;
            root_next = '0;
            cnt_next  = 5'd17;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            root_next = {root_reg[15:0], 1'b0};
            cnt_next  = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    logic [35:0] part_reg, part_next;
    logic [35:0] cand;

    // Remainder datapath kept separate for clarity.
    always_comb
    begin
        part_next = part_reg;
        cand      = '0;
        if (req.go)
        begin
            part_next = '0;
        end
        else if (busy_reg)
        begin
            part_next = {part_reg[33:0], rem_reg[33:32]};
            cand      = {17'd0, root_reg, 2'b01};
            if (part_next >= cand)
            begin
                part_next = part_next - cand;
            end
        end
    end

    logic [16:0] root_bit;
    assign root_bit = (busy_reg &&
        ({part_reg[33:0], rem_reg[33:32]} >= {17'd0, root_reg, 2'b01})) ? 17'd1 : 17'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        root_reg <= (busy_reg && !req.go) ? (root_next | root_bit) : root_next;
        rem_reg  <= (busy_reg && !req.go) ? {rem_next[31:0], 2'b00} : rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

FILE: sv/stroke_route_sampler_top.sv
// Top level of the stroke route sampler: control, route memories and ranking.
// An item is taken when start is high and busy is low. A touch, an ignored event and
// an empty release are handled without leaving the idle state. A move whose step is
// shorter than min_move uses one 17-step square root on the shared bit-serial unit;
// any other move uses two, plus a memory read. On a release of an N-point route, for
// each point the rank pass reads every point through the one read port of each route
// memory, and a 20-step division then scales the ranks. Results appear one per strobe
// cycle; the receiver cannot stall them.
module stroke_route_sampler_top #(
    parameter int ROUTE_DEPTH = 32,
    parameter int COORD_BITS  = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            action,
    input  logic [COORD_BITS-1:0] pen_x,
    input  logic [COORD_BITS-1:0] pen_y,
    input  logic [COORD_BITS-1:0] prev_x,
    input  logic [COORD_BITS-1:0] prev_y,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output logic                  strobe,
    output logic [4:0]            point_index,
    output logic [3:0]            grid_x,
    output logic [3:0]            grid_y,
    output logic                  last_point
);

    localparam int AW = $clog2(ROUTE_DEPTH);
    localparam int CW = $clog2(ROUTE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(ROUTE_DEPTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ1    = 4'd1;
    localparam logic [3:0] S_SQ1W   = 4'd2;
    localparam logic [3:0] S_RD     = 4'd3;
    localparam logic [3:0] S_SQ2    = 4'd4;
    localparam logic [3:0] S_SQ2W   = 4'd5;
    localparam logic [3:0] S_DEC    = 4'd6;
    localparam logic [3:0] S_RI     = 4'd7;
    localparam logic [3:0] S_RIW    = 4'd8;
    localparam logic [3:0] S_RJ     = 4'd9;
    localparam logic [3:0] S_RJW    = 4'd10;
    localparam logic [3:0] S_MUL    = 4'd11;
    localparam logic [3:0] S_DIV    = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;

    logic [3:0]  state_reg, state_next;
    logic [15:0] bend_limit_reg;
    logic [12:0] min_move_reg;
    logic [3:0]  grid_res_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [srs_pkg::ACCUM_BITS-1:0] accum_reg, accum_next;
    logic [COORD_BITS-1:0] px_reg, py_reg, qx_reg, qy_reg;
    logic [COORD_BITS-1:0] xi_reg, yi_reg;
    logic [AW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [16:0] step_reg;
    logic [19:0] px_prod_reg, py_prod_reg;
    logic [CW-1:0] qgx_reg, qgy_reg;
    logic [19:0] remx_reg, remy_reg;
    logic [4:0]  dcnt_reg;

    // Route memories.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [COORD_BITS-1:0] wx, wy, rdx, rdy;

    srs_ram #(.WIDTH(COORD_BITS), .DEPTH(ROUTE_DEPTH)) u_ram_x (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wx), .raddr(raddr), .rdata(rdx));
    srs_ram #(.WIDTH(COORD_BITS), .DEPTH(ROUTE_DEPTH)) u_ram_y (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wy), .raddr(raddr), .rdata(rdy));

    // Shared square-root unit.
    srs_pkg::sqrt_req_t sq_req;
    srs_pkg::sqrt_rsp_t sq_rsp;
    srs_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

    logic [COORD_BITS-1:0] ax, ay, bx, by, dx, dy;
    logic [33:0] sumsq;
    always_comb
    begin
        ax = qx_reg; ay = qy_reg; bx = px_reg; by = py_reg;
        if (state_reg == S_SQ2)
        begin
            ax = rdx; ay = rdy;
        end
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        sumsq = 34'(dx * dx) + 34'(dy * dy);
    end

    logic [19:0] straight, diff;
    logic [20:0] accsum;
    logic [19:0] acc_sat;
    assign straight = 20'(sq_rsp.root);
    assign accsum   = {1'b0, accum_reg} + 21'(step_reg);
    assign acc_sat  = accsum[20] ? srs_pkg::ACCUM_MAX : accsum[19:0];
    assign diff     = (accum_reg > straight) ? accum_reg - straight : straight - accum_reg;

    logic [CW-1:0] cnt_m1;
    assign cnt_m1 = count_reg - CW'(1);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bend_limit_reg <= 16'd700;
            min_move_reg   <= 13'd30;
            grid_res_reg   <= 4'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srs_pkg::REG_BEND_LIMIT: bend_limit_reg <= cfg_data;
                srs_pkg::REG_MIN_MOVE:   min_move_reg   <= cfg_data[12:0];
                srs_pkg::REG_GRID_RES:   grid_res_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Restoring division of grid_res*rank by count, one quotient bit per cycle.
    logic [19:0] trx, try_;
    assign trx  = {remx_reg[18:0], px_prod_reg[19]};
    assign try_ = {remy_reg[18:0], py_prod_reg[19]};

    // Main sequencer.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        accum_next = accum_reg;
        i_next = i_reg; j_next = j_reg;
        rx_next = rx_reg; ry_next = ry_reg;
        we = 1'b0; waddr = '0; wx = px_reg; wy = py_reg;
        raddr = cnt_m1[AW-1:0];
        sq_req.go = 1'b0;
        sq_req.radicand = sumsq;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_IDLE;
                    case (action)
                        srs_pkg::ACT_TOUCH:
                        begin
                            we = 1'b1; waddr = '0; wx = pen_x; wy = pen_y;
                            accum_next = '0;
                            count_next = CW'(1);
                        end
                        srs_pkg::ACT_MOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_SQ1;
                            end
                        end
                        srs_pkg::ACT_RELEASE:
                        begin
                            if (accum_reg != '0 && count_reg < DEPTH_C)
                            begin
                                we = 1'b1; waddr = count_reg[AW-1:0];
                                wx = pen_x; wy = pen_y;
                                count_next = count_reg + CW'(1);
                            end
                            accum_next = '0;
                            i_next = '0; j_next = '0;
                            if (count_next != '0)
                            begin
                                state_next = S_RI;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SQ1:
            begin
                sq_req.go = 1'b1;
                state_next = S_SQ1W;
            end
            S_SQ1W:
            begin
                if (sq_rsp.done)
                begin
                    state_next = (sq_rsp.root < 17'(min_move_reg)) ? S_IDLE : S_RD;
                end
            end
            S_RD:
            begin
                accum_next = acc_sat;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                sq_req.go = 1'b1;
                state_next = S_SQ2W;
            end
            S_SQ2W:
            begin
                if (sq_rsp.done)
                begin
                    state_next = S_IDLE;
                    if (diff > 20'(bend_limit_reg) && count_reg < DEPTH_C)
                    begin
                        we = 1'b1; waddr = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                        accum_next = '0;
                    end
                end
            end
            S_RI:
            begin
                raddr = i_reg;
                state_next = S_RIW;
            end
            S_RIW:
            begin
                raddr = '0;
                j_next = '0; rx_next = '0; ry_next = '0;
                state_next = S_RJ;
            end
            S_RJ:
            begin
                // The read of entry j issued here is compared in S_RJW.
                raddr = j_reg;
                state_next = S_RJW;
            end
            S_RJW:
            begin
                raddr = j_reg;
                if (xi_reg > rdx) rx_next = rx_reg + CW'(1);
                if (yi_reg > rdy) ry_next = ry_reg + CW'(1);
                if (CW'(j_reg) == cnt_m1)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                    state_next = S_RJ;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (dcnt_reg == 5'd0)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (CW'(i_reg) == cnt_m1)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                    state_next = S_RI;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            accum_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next;
        rx_reg <= rx_next; ry_reg <= ry_next;
        if (state_reg == S_IDLE && start)
        begin
            px_reg <= pen_x; py_reg <= pen_y; qx_reg <= prev_x; qy_reg <= prev_y;
        end
        if (state_reg == S_SQ1W && sq_rsp.done)
        begin
            step_reg <= sq_rsp.root;
        end
        if (state_reg == S_RIW)
        begin
            xi_reg <= rdx; yi_reg <= rdy;
        end
        if (state_reg == S_MUL)
        begin
            px_prod_reg <= 20'(grid_res_reg * rx_reg);
            py_prod_reg <= 20'(grid_res_reg * ry_reg);
            remx_reg <= '0; remy_reg <= '0;
            qgx_reg <= '0; qgy_reg <= '0;
            dcnt_reg <= 5'd20;
        end
        if (state_reg == S_DIV && dcnt_reg != 5'd0)
        begin
            dcnt_reg <= dcnt_reg - 5'd1;
            px_prod_reg <= {px_prod_reg[18:0], 1'b0};
            py_prod_reg <= {py_prod_reg[18:0], 1'b0};
            if (trx >= 20'(count_reg))
            begin
                remx_reg <= trx - 20'(count_reg);
                qgx_reg <= {qgx_reg[CW-2:0], 1'b1};
            end
            else
            begin
                remx_reg <= trx;
                qgx_reg <= {qgx_reg[CW-2:0], 1'b0};
            end
            if (try_ >= 20'(count_reg))
            begin
                remy_reg <= try_ - 20'(count_reg);
                qgy_reg <= {qgy_reg[CW-2:0], 1'b1};
            end
            else
            begin
                remy_reg <= try_;
                qgy_reg <= {qgy_reg[CW-2:0], 1'b0};
            end
        end
    end

    // Result outputs.
    assign busy        = (state_reg != S_IDLE);
    assign strobe      = (state_reg == S_EMIT);
    assign point_index = 5'(i_reg);
    assign grid_x      = qgx_reg[3:0];
    assign grid_y      = qgy_reg[3:0];
    assign last_point  = strobe && (CW'(i_reg) == cnt_m1);

    // Checks on the sequencer.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C) else $error("route count out of range");
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy) else $error("strobe while idle");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        last_point |=> count_reg == '0) else $error("route not cleared after last point");

endmodule
